>>> rtl/rrps_pkg.sv
// Package: types, codes and sizes shared by the process scheduler modules.
`default_nettype none

package rrps_pkg;

    // Process IDs are 1..MAX_IDS, ID 0 is the kernel.
    localparam int MAX_IDS    = 15;
    localparam int ID_W       = 4;
    localparam int TABLE_SIZE = 1 << ID_W;
    localparam int QUEUE_CAP  = MAX_IDS;
    localparam int QIDX_W     = $clog2(QUEUE_CAP);
    localparam int QCNT_W     = $clog2(QUEUE_CAP + 1);
    localparam int PRIO_W     = 8;

    localparam int CMD_Q_DEPTH = 2;
    localparam int RES_Q_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_KILL    = 2'd1,
        OP_RESCHED = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_FREE_ID = 3'd1,
        ST_KILL_CUR   = 3'd2,
        ST_NOT_QUEUED = 3'd3,
        ST_READY_MT   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        K_CREATE,
        K_KILL,
        K_RESCHED,
        K_NOP
    } cmd_kind_t;

    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    target_pid;
        logic [PRIO_W-1:0]  priority_req;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    result_pid;
        logic [PRIO_W-1:0]  result_priority;
        logic [ID_W-1:0]    running_pid;
        logic [ID_W-1:0]    queue_length;
    } res_t;

    // Classified command handed from front to back.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [ID_W-1:0]    target;
        logic [PRIO_W-1:0]  prio;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/rrps_fifo.sv
// Small first-word-fall-through queue used between scheduler stages.
`default_nettype none

module rrps_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rrps_front.sv
// Front end: takes request beats, decodes the opcode and queues commands.
`default_nettype none

module rrps_front import rrps_pkg::*; #(
    parameter int CMD_Q_DEPTH = rrps_pkg::CMD_Q_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire req_t request,
    output logic      full,
    output cmd_t      cmd,
    output logic      cmd_empty,
    input  wire logic cmd_pop
);

    cmd_t      cmd_in;
    cmd_kind_t kind;
    logic [$bits(cmd_t)-1:0] cmd_bits;

    always_comb
    begin
        unique case (request.op)
            OP_CREATE:  kind = K_CREATE;
            OP_KILL:    kind = K_KILL;
            OP_RESCHED: kind = K_RESCHED;
            default:    kind = K_NOP;
        endcase
    end

    assign cmd_in.kind   = kind;
    assign cmd_in.target = request.target_pid;
    assign cmd_in.prio   = request.priority_req;

    rrps_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_bits),
        .empty (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_bits);

endmodule

`default_nettype wire

>>> rtl/rrps_back.sv
// Back end: process table, ready queue sequencer and result queue.
`default_nettype none

module rrps_back import rrps_pkg::*; #(
    parameter int RES_Q_DEPTH = rrps_pkg::RES_Q_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    input  wire logic cmd_empty,
    output logic      cmd_pop,
    output res_t      result,
    output logic      empty,
    input  wire logic pop
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_SHIFT  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    cmd_kind_t              kind_reg, kind_next;
    logic [ID_W-1:0]        target_reg, target_next;
    logic [ID_W-1:0]        pid_reg, pid_next;
    logic [QIDX_W-1:0]      idx_reg, idx_next;
    logic [QCNT_W-1:0]      count_reg, count_next;
    logic [ID_W-1:0]        cur_reg, cur_next;
    logic [TABLE_SIZE-1:0]  active_reg;

    logic [PRIO_W-1:0]      prio_reg [TABLE_SIZE];
    logic [ID_W-1:0]        q_reg [QUEUE_CAP];

    logic                   q_we;
    logic [QIDX_W-1:0]      q_waddr;
    logic [ID_W-1:0]        q_wdata;
    logic                   prio_we;
    logic                   act_set, act_clr;
    logic [ID_W-1:0]        act_addr;

    logic [ID_W-1:0]        free_id;
    logic [QCNT_W-1:0]      idx_inc;
    logic [QCNT_W-1:0]      count_dec;

    logic                   res_push, res_full;
    status_t                r_status;
    logic [ID_W-1:0]        r_pid;
    logic [PRIO_W-1:0]      r_prio;
    res_t                   res_d;
    logic [$bits(res_t)-1:0] res_bits;

    // lowest inactive ID from 1 up; 0 when the table is full
    always_comb
    begin
        free_id = '0;
        for (int i = MAX_IDS; i >= 1; i--)
        begin
            if (!active_reg[i])
            begin
                free_id = ID_W'(i);
            end
        end
    end

    assign idx_inc   = QCNT_W'(idx_reg) + QCNT_W'(1);
    assign count_dec = count_reg - QCNT_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        target_next = target_reg;
        pid_next    = pid_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        cmd_pop     = 1'b0;
        q_we        = 1'b0;
        q_waddr     = idx_reg;
        q_wdata     = '0;
        prio_we     = 1'b0;
        act_set     = 1'b0;
        act_clr     = 1'b0;
        act_addr    = free_id;
        res_push    = 1'b0;
        r_status    = ST_OK;
        r_pid       = '0;
        r_prio      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop     = 1'b1;
                    kind_next   = cmd.kind;
                    target_next = cmd.target;
                    case (cmd.kind)
                        K_CREATE:
                        begin
                            res_push = 1'b1;
                            if (free_id == '0)
                            begin
                                r_status = ST_NO_FREE_ID;
                            end
                            else
                            begin
                                act_set    = 1'b1;
                                prio_we    = 1'b1;
                                q_we       = 1'b1;
                                q_waddr    = QIDX_W'(count_reg);
                                q_wdata    = free_id;
                                count_next = count_reg + QCNT_W'(1);
                                r_pid      = free_id;
                                r_prio     = cmd.prio;
                            end
                        end
                        K_KILL:
                        begin
                            if (cmd.target == cur_reg)
                            begin
                                res_push = 1'b1;
                                r_status = ST_KILL_CUR;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        K_RESCHED:
                        begin
                            if (count_reg == '0)
                            begin
                                res_push = 1'b1;
                                r_status = ST_READY_MT;
                            end
                            else
                            begin
                                pid_next   = q_reg[0];
                                idx_next   = '0;
                                state_next = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (QCNT_W'(idx_reg) == count_reg)
                begin
                    res_push   = 1'b1;
                    r_status   = ST_NOT_QUEUED;
                    state_next = S_IDLE;
                end
                else if (q_reg[idx_reg] == target_reg)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    idx_next = QIDX_W'(idx_inc);
                end
            end
            S_SHIFT:
            begin
                if (idx_inc < count_reg)
                begin
                    // close the gap one entry per cycle
                    q_we     = 1'b1;
                    q_waddr  = idx_reg;
                    q_wdata  = q_reg[QIDX_W'(idx_inc)];
                    idx_next = QIDX_W'(idx_inc);
                end
                else
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                    count_next = count_dec;
                    if (kind_reg == K_KILL)
                    begin
                        act_clr  = 1'b1;
                        act_addr = target_reg;
                    end
                    else
                    begin
                        if (cur_reg != '0)
                        begin
                            q_we       = 1'b1;
                            q_waddr    = QIDX_W'(count_dec);
                            q_wdata    = cur_reg;
                            count_next = count_reg;
                        end
                        cur_next = pid_reg;
                        r_pid    = pid_reg;
                        r_prio   = prio_reg[pid_reg];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_d.status          = r_status;
    assign res_d.result_pid      = r_pid;
    assign res_d.result_priority = r_prio;
    assign res_d.running_pid     = cur_next;
    assign res_d.queue_length    = ID_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cur_reg    <= '0;
            active_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            if (act_set)
            begin
                active_reg[act_addr] <= 1'b1;
            end
            else if (act_clr)
            begin
                active_reg[act_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        target_reg <= target_next;
        pid_reg    <= pid_next;
        idx_reg    <= idx_next;
        if (q_we)
        begin
            q_reg[q_waddr] <= q_wdata;
        end
        if (prio_we)
        begin
            prio_reg[free_id] <= cmd.prio;
        end
    end

    rrps_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_d),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign result = res_t'(res_bits);

    // checks
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_CAP))
        else $error("ready queue count above capacity");

    a_kernel_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg[0])
        else $error("kernel slot marked active");

    a_cur_active: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg != '0) |-> active_reg[cur_reg])
        else $error("running process not active");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == S_IDLE))
        else $error("command taken while busy");

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result beat dropped");

endmodule

`default_nettype wire

>>> rtl/round_robin_process_scheduler_core.sv
// Top level of the round-robin process scheduler.
//
// Usage:
//   Request channel: drive request {op, target_pid, priority_req} and raise
//   push; the beat is taken on a rising edge with push high and full low.
//   Result channel: while empty is low the oldest result beat sits on
//   result; raise pop to take it. Every request gives exactly one result.
// Processing:
//   A request passes a two-entry command queue, then the back end runs it.
//   Create, kill of the running process, empty reschedule and no-op are
//   answered straight from the idle state. Kill searches the ready queue for
//   the target, then shifts the entries behind it up; reschedule takes the head and shifts.
//   One request runs at a time; the ready queue shift (one entry per cycle
//   through a single write port) sets the per-item time.
// Reset: table cleared, ready queue empty, kernel (ID 0) running; both
//   internal queues empty.
// Stall: results collect in a two-entry result queue; when it is full the
//   back end waits, then the command queue fills and full rises.
`default_nettype none

module round_robin_process_scheduler_core import rrps_pkg::*; #(
    parameter int CMD_Q_DEPTH = rrps_pkg::CMD_Q_DEPTH,
    parameter int RES_Q_DEPTH = rrps_pkg::RES_Q_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire req_t request,
    output logic      full,
    output res_t      result,
    output logic      empty,
    input  wire logic pop
);

    cmd_t cmd;
    logic cmd_empty;
    logic cmd_pop;

    // front end: decode and buffer
    rrps_front #(
        .CMD_Q_DEPTH (CMD_Q_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop)
    );

    // back end: table, ready queue, result buffer
    rrps_back #(
        .RES_Q_DEPTH (RES_Q_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire
